/* src/grid_bfs_distance_and_reach_unit_macros.svh */
// Assertion helpers shared by the checking code of the grid search block.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef GRID_BFS_DISTANCE_AND_REACH_UNIT_MACROS_SVH
`define GRID_BFS_DISTANCE_AND_REACH_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBFS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("grid search check failed");

// The consequent must hold in the cycle after the antecedent.
`define GBFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("grid search check failed");

`endif

/* src/gbfs_pkg.sv */
`default_nettype none
package gbfs_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_DIST  = 2'd1;
  localparam logic [1:0] CMD_MOVE  = 2'd2;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  localparam logic RES_DIST = 1'b0;
  localparam logic RES_MOVE = 1'b1;

  localparam int COORD_W = 5;
  localparam int PATH_W  = 11;
  localparam int RANGE_W = 3;
  localparam int KIND_W  = 4;
  localparam int MASK_W  = 16;

  localparam logic [PATH_W-1:0] NOT_REACHED = 11'd99;
  localparam int MAX_RESULTS = 60;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic clr_all;
    logic clr_vis;
    logic push_start;
    logic pop_rd;
    logic pop_take;
    logic k_clear;
    logic k_inc;
    logic nb_eval;
    logic out_dist_hit;
    logic out_dist_miss;
    logic out_empty;
    logic list_init;
    logic list_rd;
    logic list_take;
  } gbfs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic q_empty;
    logic is_move;
    logic in_is_query;
    logic pop_hit;
    logic pop_stop;
    logic nb_on;
    logic k_last;
    logic list_none;
    logic out_last;
  } gbfs_stat_t;

endpackage
`default_nettype wire

/* src/grid_bfs_distance_and_reach_unit.sv */
// Grid breadth-first search unit. The block keeps a GRID_WIDTH x GRID_HEIGHT map in
// on-chip memory and takes one item at a time: a write item (cmd 0) sets one cell's
// presence, tile type and occupancy and gives no result; a distance query (cmd 1)
// returns one result with the shortest path length in tiles, counting the start, or
// 99 with the unreachable flag; a moves query (cmd 2) returns, in discovery order,
// every free walkable cell within the move range (saturated to MAX_MOVE_RANGE), at
// most 60 of them, with last set on the final one, or a single result with
// cell_valid low when none exists. Command code 3 is taken and dropped. Neighbors
// are probed up, right, down, left. After reset the block clears its map in one
// pass before it raises in_ready. A query first clears the visited map (one cell
// per cycle), then walks the queue, probing the neighbors of each dequeued cell.
// The map and visited memories are read through one registered port each, so each
// dequeued cell and each on-grid neighbor is read before it is evaluated.
// A distance answer is offered in the cycle after the search ends; each result of
// a moves query is read back from the queue before it is offered. Every result
// then waits as long as the consumer holds off out_ready. A new item is taken only
// after the last result of the previous one has been accepted.
`default_nettype none
module grid_bfs_distance_and_reach_unit import gbfs_pkg::*; #(
  parameter int GRID_WIDTH     = 32,
  parameter int GRID_HEIGHT    = 32,
  parameter int MAX_MOVE_RANGE = 5
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_cmd,
  input  wire logic [COORD_W-1:0]  in_start_x,
  input  wire logic [COORD_W-1:0]  in_start_y,
  input  wire logic [COORD_W-1:0]  in_target_x,
  input  wire logic [COORD_W-1:0]  in_target_y,
  input  wire logic [KIND_W-1:0]   in_tile_kind,
  input  wire logic                in_cell_exists,
  input  wire logic                in_cell_occupied,
  input  wire logic [MASK_W-1:0]   in_valid_mask,
  input  wire logic [RANGE_W-1:0]  in_move_range,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_result_kind,
  output logic [PATH_W-1:0]        out_path_length,
  output logic                     out_unreachable,
  output logic [COORD_W-1:0]       out_cell_col,
  output logic [COORD_W-1:0]       out_cell_row,
  output logic                     out_cell_valid,
  output logic                     out_last
);

  gbfs_cmd_t  cmd;
  gbfs_stat_t stat;

  // The controller sequences clearing, the queue walk and result delivery.
  gbfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the map, visited and queue memories and the result register.
  gbfs_dp #(
    .GRID_WIDTH     (GRID_WIDTH),
    .GRID_HEIGHT    (GRID_HEIGHT),
    .MAX_MOVE_RANGE (MAX_MOVE_RANGE)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_cmd           (in_cmd),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_target_x      (in_target_x),
    .in_target_y      (in_target_y),
    .in_tile_kind     (in_tile_kind),
    .in_cell_exists   (in_cell_exists),
    .in_cell_occupied (in_cell_occupied),
    .in_valid_mask    (in_valid_mask),
    .in_move_range    (in_move_range),
    .out_result_kind  (out_result_kind),
    .out_path_length  (out_path_length),
    .out_unreachable  (out_unreachable),
    .out_cell_col     (out_cell_col),
    .out_cell_row     (out_cell_row),
    .out_cell_valid   (out_cell_valid),
    .out_last         (out_last)
  );

endmodule
`default_nettype wire

/* src/gbfs_ram.sv */
`default_nettype none
module gbfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/gbfs_dp.sv */
`default_nettype none
module gbfs_dp import gbfs_pkg::*; #(
  parameter int GRID_WIDTH     = 32,
  parameter int GRID_HEIGHT    = 32,
  parameter int MAX_MOVE_RANGE = 5
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire gbfs_cmd_t           cmd,
  output gbfs_stat_t               stat,
  input  wire logic [1:0]          in_cmd,
  input  wire logic [COORD_W-1:0]  in_start_x,
  input  wire logic [COORD_W-1:0]  in_start_y,
  input  wire logic [COORD_W-1:0]  in_target_x,
  input  wire logic [COORD_W-1:0]  in_target_y,
  input  wire logic [KIND_W-1:0]   in_tile_kind,
  input  wire logic                in_cell_exists,
  input  wire logic                in_cell_occupied,
  input  wire logic [MASK_W-1:0]   in_valid_mask,
  input  wire logic [RANGE_W-1:0]  in_move_range,
  output logic                     out_result_kind,
  output logic [PATH_W-1:0]        out_path_length,
  output logic                     out_unreachable,
  output logic [COORD_W-1:0]       out_cell_col,
  output logic [COORD_W-1:0]       out_cell_row,
  output logic                     out_cell_valid,
  output logic                     out_last
);

  localparam int CELLS  = GRID_WIDTH * GRID_HEIGHT;
  localparam int CAW    = $clog2(CELLS);
  localparam int XW     = (GRID_WIDTH > 32) ? $clog2(GRID_WIDTH) : COORD_W;
  localparam int YW     = (GRID_HEIGHT > 32) ? $clog2(GRID_HEIGHT) : COORD_W;
  localparam int QDEPTH = CELLS + 1;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);
  localparam int DW     = QCW;
  localparam int QW     = XW + YW + DW;
  localparam int PW     = (DW > PATH_W) ? DW : PATH_W;
  localparam int MAPW   = KIND_W + 2;

  logic [1:0]         qcmd_r;
  logic [COORD_W-1:0] sx_r, sy_r, tx_r, ty_r;
  logic [MASK_W-1:0]  mask_r;
  logic [RANGE_W-1:0] range_r;
  logic [QCW-1:0]     head_r, tail_r, list_idx_r;
  logic [CAW-1:0]     clr_cnt_r;
  logic [1:0]         k_r;
  logic [XW-1:0]      cur_x_r;
  logic [YW-1:0]      cur_y_r;
  logic [DW-1:0]      cur_d_r;

  logic [XW:0]        nx;
  logic [YW:0]        ny;
  logic               nneg, nb_on, nb_pass, is_move;
  logic [CAW-1:0]     nb_addr, s_addr, w_addr;
  logic               s_on, w_on;
  logic [MAPW-1:0]    map_q;
  logic               vis_q;
  logic [QW-1:0]      q_rd, q_wd;
  logic [XW-1:0]      q_x;
  logic [YW-1:0]      q_y;
  logic [DW-1:0]      q_d;
  logic [PW-1:0]      dist_path;
  logic [QCW-1:0]     tail_m1, list_n;
  logic               map_we, vis_we, vis_wd, q_we, clr;
  logic [CAW-1:0]     map_waddr, vis_waddr;
  logic [MAPW-1:0]    map_wd;
  logic [QAW-1:0]     q_waddr, q_raddr;

  assign is_move = (qcmd_r == CMD_MOVE);
  assign clr     = cmd.clr_all | cmd.clr_vis;

  // Neighbor of the current cell in direction k.
  always_comb begin
    nx   = {1'b0, cur_x_r};
    ny   = {1'b0, cur_y_r};
    nneg = 1'b0;
    unique case (k_r)
      DIR_UP:    ny = ny + (YW+1)'(1);
      DIR_RIGHT: nx = nx + (XW+1)'(1);
      DIR_DOWN: begin
        nneg = (cur_y_r == '0);
        ny   = ny - (YW+1)'(1);
      end
      DIR_LEFT: begin
        nneg = (cur_x_r == '0);
        nx   = nx - (XW+1)'(1);
      end
      default: ;
    endcase
  end

  assign nb_on   = !nneg && (nx < (XW+1)'(GRID_WIDTH)) && (ny < (YW+1)'(GRID_HEIGHT));
  assign nb_addr = CAW'(ny[YW-1:0]) * CAW'(GRID_WIDTH) + CAW'(nx[XW-1:0]);

  assign s_on   = (int'(sx_r) < GRID_WIDTH) && (int'(sy_r) < GRID_HEIGHT);
  assign s_addr = CAW'(sy_r) * CAW'(GRID_WIDTH) + CAW'(sx_r);
  assign w_on   = (int'(in_start_x) < GRID_WIDTH) && (int'(in_start_y) < GRID_HEIGHT);
  assign w_addr = CAW'(in_start_y) * CAW'(GRID_WIDTH) + CAW'(in_start_x);

  assign nb_pass = map_q[KIND_W+1] && mask_r[map_q[KIND_W-1:0]] && !vis_q
                   && !(is_move && map_q[KIND_W]);

  // Cell map: presence, occupancy, tile type.
  assign map_we    = cmd.clr_all | (cmd.accept && (in_cmd == CMD_WRITE) && w_on);
  assign map_waddr = cmd.clr_all ? clr_cnt_r : w_addr;
  assign map_wd    = cmd.clr_all ? '0 : {in_cell_exists, in_cell_occupied, in_tile_kind};

  gbfs_ram #(.WIDTH(MAPW), .DEPTH(CELLS)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wd),
    .raddr(nb_addr), .rdata(map_q)
  );

  assign vis_we    = clr | (cmd.push_start && s_on) | (cmd.nb_eval && nb_pass);
  assign vis_waddr = clr ? clr_cnt_r : (cmd.push_start ? s_addr : nb_addr);
  assign vis_wd    = !clr;

  gbfs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_vis (
    .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wd),
    .raddr(nb_addr), .rdata(vis_q)
  );

  assign q_we    = cmd.push_start | (cmd.nb_eval && nb_pass);
  assign q_waddr = cmd.push_start ? '0 : tail_r[QAW-1:0];
  assign q_wd    = cmd.push_start ? {XW'(sx_r), YW'(sy_r), DW'(0)}
                                  : {nx[XW-1:0], ny[YW-1:0], cur_d_r + DW'(1)};
  assign q_raddr = cmd.list_rd ? list_idx_r[QAW-1:0] : head_r[QAW-1:0];

  gbfs_ram #(.WIDTH(QW), .DEPTH(QDEPTH)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wd),
    .raddr(q_raddr), .rdata(q_rd)
  );

  assign q_x       = q_rd[QW-1 -: XW];
  assign q_y       = q_rd[DW +: YW];
  assign q_d       = q_rd[DW-1:0];
  assign dist_path = PW'(q_d) + PW'(1);

  assign tail_m1 = tail_r - QCW'(1);
  assign list_n  = (tail_m1 > QCW'(MAX_RESULTS)) ? QCW'(MAX_RESULTS) : tail_m1;

  always_comb begin
    stat             = '0;
    stat.clr_done    = (clr_cnt_r == CAW'(CELLS - 1));
    stat.q_empty     = (head_r == tail_r);
    stat.is_move     = is_move;
    stat.in_is_query = (in_cmd == CMD_DIST) || (in_cmd == CMD_MOVE);
    stat.pop_hit     = (q_x == XW'(tx_r)) && (q_y == YW'(ty_r));
    stat.pop_stop    = (q_d >= DW'(range_r));
    stat.nb_on       = nb_on;
    stat.k_last      = (k_r == DIR_LEFT);
    stat.list_none   = (tail_r == QCW'(1));
    stat.out_last    = out_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      tail_r     <= '0;
      clr_cnt_r  <= '0;
      k_r        <= '0;
      list_idx_r <= '0;
    end else begin
      if (clr) begin
        clr_cnt_r <= stat.clr_done ? '0 : clr_cnt_r + CAW'(1);
      end
      if (cmd.push_start) begin
        head_r <= '0;
        tail_r <= QCW'(1);
      end
      if (cmd.pop_rd) begin
        head_r <= head_r + QCW'(1);
      end
      if (cmd.nb_eval && nb_pass) begin
        tail_r <= tail_r + QCW'(1);
      end
      if (cmd.k_clear) begin
        k_r <= '0;
      end else if (cmd.k_inc) begin
        k_r <= k_r + 2'd1;
      end
      if (cmd.list_init) begin
        list_idx_r <= QCW'(1);
      end else if (cmd.list_take) begin
        list_idx_r <= list_idx_r + QCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      qcmd_r  <= in_cmd;
      sx_r    <= in_start_x;
      sy_r    <= in_start_y;
      tx_r    <= in_target_x;
      ty_r    <= in_target_y;
      mask_r  <= in_valid_mask;
      range_r <= (in_move_range > RANGE_W'(MAX_MOVE_RANGE)) ? RANGE_W'(MAX_MOVE_RANGE)
                                                            : in_move_range;
    end
    if (cmd.pop_take) begin
      cur_x_r <= q_x;
      cur_y_r <= q_y;
      cur_d_r <= q_d;
    end
    if (cmd.out_dist_hit || cmd.out_dist_miss || cmd.out_empty) begin
      out_result_kind <= cmd.out_empty ? RES_MOVE : RES_DIST;
      out_path_length <= cmd.out_dist_hit ? dist_path[PATH_W-1:0]
                       : (cmd.out_dist_miss ? NOT_REACHED : '0);
      out_unreachable <= cmd.out_dist_miss;
      out_cell_col    <= '0;
      out_cell_row    <= '0;
      out_cell_valid  <= 1'b0;
      out_last        <= 1'b1;
    end else if (cmd.list_take) begin
      out_result_kind <= RES_MOVE;
      out_path_length <= '0;
      out_unreachable <= 1'b0;
      out_cell_col    <= q_x[COORD_W-1:0];
      out_cell_row    <= q_y[COORD_W-1:0];
      out_cell_valid  <= 1'b1;
      out_last        <= (list_idx_r == list_n);
    end
  end

endmodule
`default_nettype wire

/* src/gbfs_ctrl.sv */
`default_nettype none
module gbfs_ctrl import gbfs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire gbfs_stat_t stat,
  output gbfs_cmd_t       cmd
);

  localparam logic [3:0] S_RCLR  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_VCLR  = 4'd2;
  localparam logic [3:0] S_START = 4'd3;
  localparam logic [3:0] S_POP   = 4'd4;
  localparam logic [3:0] S_POPW  = 4'd5;
  localparam logic [3:0] S_NBR   = 4'd6;
  localparam logic [3:0] S_NBE   = 4'd7;
  localparam logic [3:0] S_LIST  = 4'd8;
  localparam logic [3:0] S_LISTW = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0] state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_RCLR: begin
        cmd.clr_all = 1'b1;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (stat.in_is_query) state_nxt = S_VCLR;
        end
      end
      S_VCLR: begin
        cmd.clr_vis = 1'b1;
        if (stat.clr_done) state_nxt = S_START;
      end
      S_START: begin
        cmd.push_start = 1'b1;
        state_nxt      = S_POP;
      end
      S_POP: begin
        if (stat.q_empty) begin
          if (stat.is_move) begin
            cmd.list_init = 1'b1;
            state_nxt     = S_LIST;
          end else begin
            cmd.out_dist_miss = 1'b1;
            state_nxt         = S_OUT;
          end
        end else begin
          cmd.pop_rd = 1'b1;
          state_nxt  = S_POPW;
        end
      end
      S_POPW: begin
        cmd.pop_take = 1'b1;
        if (!stat.is_move && stat.pop_hit) begin
          cmd.out_dist_hit = 1'b1;
          state_nxt        = S_OUT;
        end else if (stat.is_move && stat.pop_stop) begin
          state_nxt = S_POP;
        end else begin
          cmd.k_clear = 1'b1;
          state_nxt   = S_NBR;
        end
      end
      S_NBR: begin
        if (stat.nb_on) begin
          state_nxt = S_NBE;
        end else if (stat.k_last) begin
          state_nxt = S_POP;
        end else begin
          cmd.k_inc = 1'b1;
        end
      end
      S_NBE: begin
        cmd.nb_eval = 1'b1;
        if (stat.k_last) begin
          state_nxt = S_POP;
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = S_NBR;
        end
      end
      S_LIST: begin
        if (stat.list_none) begin
          cmd.out_empty = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          cmd.list_rd = 1'b1;
          state_nxt   = S_LISTW;
        end
      end
      S_LISTW: begin
        cmd.list_take = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = stat.out_last ? S_IDLE : S_LIST;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RCLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/gbfs_checker.sv */
`default_nettype none
`include "grid_bfs_distance_and_reach_unit_macros.svh"
module gbfs_checker import gbfs_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic [1:0]          in_cmd,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic                out_result_kind,
  input wire logic [PATH_W-1:0]   out_path_length,
  input wire logic                out_unreachable,
  input wire logic [COORD_W-1:0]  out_cell_col,
  input wire logic [COORD_W-1:0]  out_cell_row,
  input wire logic                out_cell_valid,
  input wire logic                out_last
);

  logic [PATH_W+2*COORD_W+3:0] out_word;

  assign out_word = {out_result_kind, out_path_length, out_unreachable, out_cell_col,
                     out_cell_row, out_cell_valid, out_last};

  // One item at a time: no new item is taken while a result is on offer.
  `GBFS_ASSERT_NOW(a_ready_excl, in_ready, !out_valid)
  // A write item produces no result.
  `GBFS_ASSERT_NEXT(a_write_silent, in_valid && in_ready && in_cmd == CMD_WRITE, !out_valid)
  // Nothing follows the final result of a query.
  `GBFS_ASSERT_NEXT(a_last_ends, out_valid && out_ready && out_last, !out_valid)
  // A stalled result holds.
  `GBFS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))

endmodule

bind grid_bfs_distance_and_reach_unit gbfs_checker u_gbfs_checker (.*);
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 100ps
`default_nettype none
// Self-checking bench for the grid search unit. A driver feeds items from a
// queue, a model of the map and the search predicts each result, and a
// monitor compares every accepted result field by field against the oldest
// prediction. The stimulus is built in phases with different amounts of
// sender idling and receiver back-pressure.
module tb_top;
  import gbfs_pkg::*;

  // One input item, one field per port.
  typedef struct {
    logic [1:0]         cmd;
    logic [COORD_W-1:0] sx, sy, tx, ty;
    logic [KIND_W-1:0]  kind;
    logic               exists, occupied;
    logic [MASK_W-1:0]  mask;
    logic [RANGE_W-1:0] range;
  } grid_item_t;

  // One result item as the block presents it.
  typedef struct {
    logic               kind;
    logic [PATH_W-1:0]  len;
    logic               unr;
    logic [COORD_W-1:0] col, row;
    logic               valid, last;
  } search_res_t;

  localparam int GRID_W      = 32;
  localparam int GRID_H      = 32;
  localparam int RANGE_CAP   = 5;
  localparam int STALL_LIMIT = 60000;
  localparam int DRAIN_WAIT  = 64;

  // The one command code the block ignores.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          in_cmd = CMD_WRITE;
  logic [COORD_W-1:0]  in_start_x = '0, in_start_y = '0;
  logic [COORD_W-1:0]  in_target_x = '0, in_target_y = '0;
  logic [KIND_W-1:0]   in_tile_kind = '0;
  logic                in_cell_exists = 1'b0, in_cell_occupied = 1'b0;
  logic [MASK_W-1:0]   in_valid_mask = '0;
  logic [RANGE_W-1:0]  in_move_range = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_result_kind;
  logic [PATH_W-1:0]   out_path_length;
  logic                out_unreachable;
  logic [COORD_W-1:0]  out_cell_col, out_cell_row;
  logic                out_cell_valid, out_last;

  grid_bfs_distance_and_reach_unit i_dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_cmd, .in_start_x, .in_start_y,
    .in_target_x, .in_target_y, .in_tile_kind, .in_cell_exists,
    .in_cell_occupied, .in_valid_mask, .in_move_range,
    .out_valid, .out_ready, .out_result_kind, .out_path_length,
    .out_unreachable, .out_cell_col, .out_cell_row, .out_cell_valid,
    .out_last
  );

  // Items waiting to be driven, and the results the map model expects.
  grid_item_t  pending_items[$];
  search_res_t expected_results[$];

  // The bench's own copy of the map.
  logic [KIND_W-1:0] tile_mem[GRID_W*GRID_H];
  logic              present_mem[GRID_W*GRID_H];
  logic              occupied_mem[GRID_W*GRID_H];

  int  sender_idle_pct = 0;
  int  receiver_stall_pct = 0;
  int  n_errors = 0;
  int  n_items = 0, n_dist = 0, n_moves = 0, n_results = 0, n_unreach = 0;
  int  stall_cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Applies one accepted item to the map model and queues the results it
  // should produce. The search mirrors the block: breadth-first, neighbors
  // probed up, right, down, left, the start taken as root unchecked.
  task automatic model_item(input grid_item_t it);
    int qx[GRID_W*GRID_H+1], qy[GRID_W*GRID_H+1], qd[GRID_W*GRID_H+1];
    bit seen[GRID_W*GRID_H];
    int head, tail, x, y, d, nx, ny, c, lim, found, cnt;
    bit is_move;
    search_res_t r;
    if (it.cmd == CMD_WRITE) begin
      c = it.sy * GRID_W + it.sx;
      tile_mem[c] = it.kind;
      present_mem[c] = it.exists;
      occupied_mem[c] = it.occupied;
      return;
    end
    if (it.cmd != CMD_DIST && it.cmd != CMD_MOVE) return;
    is_move = (it.cmd == CMD_MOVE);
    lim = (it.range > RANGE_CAP) ? RANGE_CAP : it.range;
    for (int i = 0; i < GRID_W*GRID_H; i++) seen[i] = 1'b0;
    qx[0] = it.sx; qy[0] = it.sy; qd[0] = 0;
    seen[it.sy * GRID_W + it.sx] = 1'b1;
    head = 0; tail = 1; found = 0;
    while (head < tail) begin
      x = qx[head]; y = qy[head]; d = qd[head];
      head++;
      if (!is_move && x == it.tx && y == it.ty) begin
        found = d + 1;
        break;
      end
      if (is_move && d >= lim) continue;
      for (int k = 0; k < 4; k++) begin
        nx = x + ((k == DIR_RIGHT) ? 1 : (k == DIR_LEFT) ? -1 : 0);
        ny = y + ((k == DIR_UP) ? 1 : (k == DIR_DOWN) ? -1 : 0);
        if (nx < 0 || nx >= GRID_W || ny < 0 || ny >= GRID_H) continue;
        c = ny * GRID_W + nx;
        if (!present_mem[c] || !it.mask[tile_mem[c]] || seen[c]) continue;
        if (is_move && occupied_mem[c]) continue;
        seen[c] = 1'b1;
        qx[tail] = nx; qy[tail] = ny; qd[tail] = d + 1;
        tail++;
      end
    end
    r = '{kind: RES_DIST, len: '0, unr: 1'b0, col: '0, row: '0, valid: 1'b0,
          last: 1'b1};
    if (!is_move) begin
      n_dist++;
      if (found == 0) begin
        r.len = NOT_REACHED;
        r.unr = 1'b1;
        n_unreach++;
      end else begin
        r.len = found[PATH_W-1:0];
      end
      expected_results.push_back(r);
      return;
    end
    n_moves++;
    r.kind = RES_MOVE;
    cnt = (tail - 1 > MAX_RESULTS) ? MAX_RESULTS : tail - 1;
    if (cnt == 0) begin
      expected_results.push_back(r);
      return;
    end
    for (int i = 1; i <= cnt; i++) begin
      r.col = qx[i][COORD_W-1:0];
      r.row = qy[i][COORD_W-1:0];
      r.valid = 1'b1;
      r.last = (i == cnt);
      expected_results.push_back(r);
    end
  endtask

  // Driver: a new item goes out only once the previous one is taken, so
  // valid stays high with a stable payload until the handshake.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        grid_item_t it;
        it = pending_items.pop_front();
        in_valid         <= 1'b1;
        in_cmd           <= it.cmd;
        in_start_x       <= it.sx;
        in_start_y       <= it.sy;
        in_target_x      <= it.tx;
        in_target_y      <= it.ty;
        in_tile_kind     <= it.kind;
        in_cell_exists   <= it.exists;
        in_cell_occupied <= it.occupied;
        in_valid_mask    <= it.mask;
        in_move_range    <= it.range;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Prediction happens on the accepting edge, from the payload still held.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      model_item('{cmd: in_cmd, sx: in_start_x, sy: in_start_y, tx: in_target_x,
                   ty: in_target_y, kind: in_tile_kind, exists: in_cell_exists,
                   occupied: in_cell_occupied, mask: in_valid_mask,
                   range: in_move_range});
      n_items++;
    end
  end

  // Monitor: random back-pressure and a field-by-field compare.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
      if (out_valid && out_ready) begin
        n_results++;
        if (expected_results.size() == 0) begin
          $error("result arrived with nothing expected");
          n_errors++;
        end else begin
          search_res_t e;
          e = expected_results.pop_front();
          if (out_result_kind !== e.kind) begin
            $error("result_kind: expected %0d, got %0d", e.kind, out_result_kind);
            n_errors++;
          end
          if (out_path_length !== e.len) begin
            $error("path_length: expected %0d, got %0d", e.len, out_path_length);
            n_errors++;
          end
          if (out_unreachable !== e.unr) begin
            $error("unreachable: expected %0d, got %0d", e.unr, out_unreachable);
            n_errors++;
          end
          if (out_cell_col !== e.col) begin
            $error("cell_col: expected %0d, got %0d", e.col, out_cell_col);
            n_errors++;
          end
          if (out_cell_row !== e.row) begin
            $error("cell_row: expected %0d, got %0d", e.row, out_cell_row);
            n_errors++;
          end
          if (out_cell_valid !== e.valid) begin
            $error("cell_valid: expected %0d, got %0d", e.valid, out_cell_valid);
            n_errors++;
          end
          if (out_last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, out_last);
            n_errors++;
          end
        end
      end
    end
  end

  // Watchdog: no handshake happens during a long search or the clearing pass
  // after reset, so the limit is generous.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic grid_item_t write_item(int x, int y, int kind, bit ex, bit occ);
    grid_item_t it;
    it = '{cmd: CMD_WRITE, sx: COORD_W'(x), sy: COORD_W'(y),
           tx: COORD_W'($urandom), ty: COORD_W'($urandom), kind: KIND_W'(kind),
           exists: ex, occupied: occ, mask: MASK_W'($urandom),
           range: RANGE_W'($urandom)};
    return it;
  endfunction

  function automatic grid_item_t query_item(logic [1:0] cmd, int sx, int sy,
                                            int tx, int ty, int mask, int rng);
    grid_item_t it;
    it = '{cmd: cmd, sx: COORD_W'(sx), sy: COORD_W'(sy), tx: COORD_W'(tx),
           ty: COORD_W'(ty), kind: KIND_W'($urandom), exists: 1'($urandom),
           occupied: 1'($urandom), mask: MASK_W'(mask), range: RANGE_W'(rng)};
    return it;
  endfunction

  // Random items are clustered in a small window so searches meet real
  // paths, walls and occupied cells; the window sometimes sits against the
  // grid edges so off-grid neighbors are probed.
  function automatic grid_item_t random_item(int bx, int by);
    int sel, mask;
    sel = $urandom_range(99);
    mask = ($urandom_range(3) == 0) ? $urandom :
           ($urandom_range(4) == 0) ? 16'hFFFF : (16'h000F | ($urandom & 16'hFF00));
    if (sel < 50)
      return write_item(bx + $urandom_range(7), by + $urandom_range(7),
                        ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(3),
                        $urandom_range(99) < 85, $urandom_range(99) < 20);
    if (sel < 53)
      return query_item(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom);
    if (sel < 58)
      return query_item(sel < 56 ? CMD_DIST : CMD_MOVE, $urandom, $urandom,
                        $urandom, $urandom, mask, $urandom);
    if (sel < 78)
      return query_item(CMD_DIST, bx + $urandom_range(7), by + $urandom_range(7),
                        bx + $urandom_range(7), by + $urandom_range(7), mask, $urandom);
    return query_item(CMD_MOVE, bx + $urandom_range(7), by + $urandom_range(7),
                      $urandom, $urandom, mask, $urandom_range(7));
  endfunction

  task automatic wait_for_drain();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    int base_x[3] = '{0, 24, 12};
    int base_y[3] = '{0, 24, 12};
    int w;
    for (int i = 0; i < GRID_W*GRID_H; i++) begin
      tile_mem[i] = '0;
      present_mem[i] = 1'b0;
      occupied_mem[i] = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part on the empty map and a few hand-placed cells: start
    // equal to target, an absent target, an empty move set, range zero and
    // range above the cap, the unknown command, and the field extremes.
    pending_items.push_back(query_item(CMD_DIST, 5, 5, 5, 5, 16'h0000, 0));
    pending_items.push_back(query_item(CMD_DIST, 0, 0, 31, 31, 16'hFFFF, 0));
    pending_items.push_back(query_item(CMD_MOVE, 31, 31, 0, 0, 16'hFFFF, 5));
    pending_items.push_back(write_item(0, 1, 15, 1, 0));
    pending_items.push_back(write_item(1, 0, 0, 1, 1));
    pending_items.push_back(write_item(1, 1, 0, 1, 0));
    pending_items.push_back(write_item(31, 31, 15, 1, 1));
    pending_items.push_back(write_item(31, 30, 7, 1, 0));
    pending_items.push_back(write_item(30, 31, 7, 0, 0));
    pending_items.push_back(query_item(CMD_UNUSED, 31, 31, 31, 31, 16'hFFFF, 7));
    pending_items.push_back(query_item(CMD_DIST, 0, 0, 1, 1, 16'hFFFF, 0));
    pending_items.push_back(query_item(CMD_DIST, 0, 0, 1, 1, 16'h0001, 0));
    pending_items.push_back(query_item(CMD_DIST, 0, 0, 1, 1, 16'h8000, 0));
    pending_items.push_back(query_item(CMD_MOVE, 0, 0, 0, 0, 16'hFFFF, 0));
    pending_items.push_back(query_item(CMD_MOVE, 0, 0, 0, 0, 16'hFFFF, 7));
    pending_items.push_back(query_item(CMD_MOVE, 0, 0, 0, 0, 16'h8000, 1));
    pending_items.push_back(query_item(CMD_DIST, 31, 31, 31, 30, 16'h0080, 0));
    pending_items.push_back(query_item(CMD_DIST, 30, 30, 31, 31, 16'hFFFF, 0));
    pending_items.push_back(query_item(CMD_MOVE, 30, 30, 0, 0, 16'hFFFF, 5));
    pending_items.push_back(query_item(CMD_DIST, 31, 31, 30, 31, 16'hFFFF, 0));
    // Sender holds back until every result so far has come back.
    wait_for_drain();

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct    = (ph == 1) ? 70 : (ph == 3) ? 15 : 0;
      receiver_stall_pct = (ph == 2) ? 70 : (ph == 3) ? 15 : 0;
      w = $urandom_range(2);
      for (int i = 0; i < 30; i++)
        pending_items.push_back(random_item(base_x[w], base_y[w]));
      wait_for_drain();
    end
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d items: %0d distance queries (%0d unreachable), %0d move queries,",
             n_items, n_dist, n_unreach, n_moves);
    $display("%0d results checked under four idling and back-pressure phases.", n_results);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
